// ----- src/desp_pkg.sv -----
// ----------------------------------------------------------------------------
// desp_pkg
// shared types and constants of the dual encoder speed pi loop
// ----------------------------------------------------------------------------
package desp_pkg;

  // widths of the fixed fields
  localparam int unsigned CountW  = 16;
  localparam int unsigned SpeedW  = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned TickW   = 8;
  localparam int unsigned FracW   = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned MulW    = 17;

  localparam int unsigned IntegBitsDefault = 40;

  // register reset values
  localparam logic [GainW-1:0]  PropGainRst  = 16'd15238;
  localparam logic [GainW-1:0]  IntGainRst   = 16'd2193;
  localparam logic [DutyW-1:0]  DutyHighRst  = 8'd99;
  localparam logic [DutyW-1:0]  DutyLowRst   = 8'd0;
  localparam logic [TickW-1:0]  PeriodRst    = 8'd10;
  localparam logic [GainW-1:0]  SpeedScaleRst = 16'd1667;

  // target override: 100 rpm limit, 70 rpm fallback, in 1/256 rpm
  localparam logic [SpeedW-1:0] TargetLimit    = 16'd25600;
  localparam logic [SpeedW-1:0] TargetFallback = 16'd17920;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INT_GAIN    = 3'd1,
    REG_DUTY_HIGH   = 3'd2,
    REG_DUTY_LOW    = 3'd3,
    REG_PERIOD      = 3'd4,
    REG_SPEED_SCALE = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPEED,
    S_ERR,
    S_PTERM,
    S_ITERM,
    S_INTEG,
    S_SUM,
    S_DUTY
  } state_e;

endpackage

// ----- src/dual_encoder_speed_pi_loop_unit.sv -----
// ----------------------------------------------------------------------------
// dual_encoder_speed_pi_loop_unit
// two-wheel encoder speed measurement and pi duty controller
// ----------------------------------------------------------------------------
// an item without a control update is taken in idle, ready stays high unless
// a finished result still waits for the output register; an update item runs
// speed, err, pterm, iterm, integ, sum and duty for each wheel through the shared
// 17x17 multiplier and adder sequence, then moves into the output register; no
// item is taken meanwhile, and the result waits there while the next items are taken
// async active-low reset loads the config reset values and clears state, counters and both integrators
module dual_encoder_speed_pi_loop_unit
  import desp_pkg::*;
#(
  parameter int unsigned IntegBits = IntegBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  // input beats
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // left_edges[1:0], right_edges[3:2], left_target[19:4],
  // right_target[35:20], zero pad [39:36]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tick[0]
  input  logic [0:0]          s_axis_tuser_i,
  // result beats
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // left_duty[7:0], right_duty[15:8], left_speed[31:16], right_speed[47:32]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  // adder width: covers integrator and the 34-bit products with one guard bit
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned AddW  = ((IntegBits > ProdW) ? IntegBits : ProdW) + 1;
  localparam logic signed [AddW-1:0] IntMax =
    {{(AddW - IntegBits + 1){1'b0}}, {(IntegBits - 1){1'b1}}};
  localparam logic signed [AddW-1:0] IntMin = ~IntMax;

  // configuration registers
  logic [GainW-1:0] prop_gain_q, int_gain_q, speed_scale_q;
  logic [DutyW-1:0] duty_high_q, duty_low_q;
  logic [TickW-1:0] period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= PropGainRst;
      int_gain_q    <= IntGainRst;
      duty_high_q   <= DutyHighRst;
      duty_low_q    <= DutyLowRst;
      period_q      <= PeriodRst;
      speed_scale_q <= SpeedScaleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROP_GAIN:   prop_gain_q   <= cfg_data_i;
        REG_INT_GAIN:    int_gain_q    <= cfg_data_i;
        REG_DUTY_HIGH:   duty_high_q   <= cfg_data_i[DutyW-1:0];
        REG_DUTY_LOW:    duty_low_q    <= cfg_data_i[DutyW-1:0];
        REG_PERIOD:      period_q      <= cfg_data_i[TickW-1:0];
        REG_SPEED_SCALE: speed_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input field unpacking
  logic                in_tick;
  logic [1:0]          in_edges [2];
  logic [SpeedW-1:0]   in_target [2];

  assign in_tick      = s_axis_tuser_i[0];
  assign in_edges[0]  = s_axis_tdata_i[1:0];
  assign in_edges[1]  = s_axis_tdata_i[3:2];
  assign in_target[0] = s_axis_tdata_i[19:4];
  assign in_target[1] = s_axis_tdata_i[35:20];

  // sequencer state
  state_e state_q, state_d;
  logic   wheel_q;
  logic   out_valid_q;
  logic   in_fire;
  logic   update;        // beat closes a control period if it is accepted

  // per-wheel storage
  logic [CountW-1:0]           cnt_q    [2];
  logic [CountW-1:0]           lat_q    [2];
  logic [SpeedW-1:0]           tgt_q    [2];
  logic signed [IntegBits-1:0] integ_q  [2];
  logic [SpeedW-1:0]           speed_q  [2];
  logic [DutyW-1:0]            duty_q   [2];
  logic [TickW-1:0]            tick_cnt_q;

  // shared datapath registers
  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] pterm_q;
  logic signed [MulW-1:0]  err_q;
  logic signed [AddW-1:0]  sum_q;
  logic                    result_pend_q;  // finished result not yet in output reg

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  // tick period compare; period zero acts as one
  logic [TickW:0]   tick_inc;
  logic [TickW-1:0] period_eff;
  assign period_eff = (period_q == '0) ? TickW'(1) : period_q;
  assign tick_inc   = {1'b0, tick_cnt_q} + (TickW + 1)'(1);
  assign update     = in_tick && (tick_inc >= {1'b0, period_eff});

  // saturating edge counters for this beat
  logic [CountW:0]   cnt_sum [2];
  logic [CountW-1:0] cnt_new [2];
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      cnt_sum[w] = {1'b0, cnt_q[w]} + (CountW + 1)'(in_edges[w]);
      cnt_new[w] = cnt_sum[w][CountW] ? {CountW{1'b1}} : cnt_sum[w][CountW-1:0];
    end
  end

  // target override when either target is above the limit
  logic override;
  assign override = (in_target[0] > TargetLimit) || (in_target[1] > TargetLimit);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire && update) state_d = S_SPEED;
      S_SPEED: state_d = S_ERR;
      S_ERR:   state_d = S_PTERM;
      S_PTERM: state_d = S_ITERM;
      S_ITERM: state_d = S_INTEG;
      S_INTEG: state_d = S_SUM;
      S_SUM:   state_d = S_DUTY;
      S_DUTY:  state_d = wheel_q ? S_IDLE : S_SPEED;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs: ready and multiplier operand select
  logic signed [MulW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;
  always_comb begin
    s_axis_tready_o = 1'b0;
    mul_a = $signed({1'b0, lat_q[wheel_q]});
    mul_b = $signed({1'b0, speed_scale_q});
    case (state_q)
      // wait while a finished result still has no room in the output reg
      S_IDLE:  s_axis_tready_o = !result_pend_q;
      S_PTERM: begin
        mul_a = err_q;
        mul_b = $signed({1'b0, prop_gain_q});
      end
      S_ITERM: begin
        mul_a = err_q;
        mul_b = $signed({1'b0, int_gain_q});
      end
      default: ;
    endcase
  end

  // the one shared multiplier
  assign mul_p = mul_a * mul_b;

  // speed saturation of the product (always non-negative there)
  logic [SpeedW-1:0] speed_sat;
  assign speed_sat = (prod_q[ProdW-1:SpeedW] != '0) ? {SpeedW{1'b1}}
                                                   : prod_q[SpeedW-1:0];

  // shared adder: integrator update or p plus i
  logic signed [AddW-1:0] add_a, add_b, add_s;
  always_comb begin
    add_a = AddW'(integ_q[wheel_q]);
    add_b = (state_q == S_INTEG) ? AddW'(prod_q) : AddW'(pterm_q);
  end
  assign add_s = add_a + add_b;

  // duty clamp limits in 2^-24 units
  logic signed [AddW-1:0] hi_lim, lo_lim;
  logic [DutyW-1:0]       duty_val;
  assign hi_lim = AddW'($signed({1'b0, duty_high_q, {FracW{1'b0}}}));
  assign lo_lim = AddW'($signed({1'b0, duty_low_q, {FracW{1'b0}}}));
  always_comb begin
    if (sum_q > hi_lim) begin
      duty_val = duty_high_q;
    end else if (sum_q < lo_lim) begin
      duty_val = duty_low_q;
    end else begin
      duty_val = sum_q[FracW+DutyW-1:FracW];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      wheel_q       <= 1'b0;
      tick_cnt_q    <= '0;
      cnt_q[0]      <= '0;
      cnt_q[1]      <= '0;
      integ_q[0]    <= '0;
      integ_q[1]    <= '0;
      out_valid_q   <= 1'b0;
      result_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        if (update) begin
          tick_cnt_q <= '0;
          cnt_q[0]   <= '0;
          cnt_q[1]   <= '0;
          wheel_q    <= 1'b0;
        end else begin
          cnt_q[0] <= cnt_new[0];
          cnt_q[1] <= cnt_new[1];
          if (in_tick) tick_cnt_q <= tick_inc[TickW-1:0];
        end
      end
      if (state_q == S_INTEG) begin
        // saturate the integrator at its signed limits
        if (add_s > IntMax) begin
          integ_q[wheel_q] <= IntMax[IntegBits-1:0];
        end else if (add_s < IntMin) begin
          integ_q[wheel_q] <= IntMin[IntegBits-1:0];
        end else begin
          integ_q[wheel_q] <= add_s[IntegBits-1:0];
        end
      end
      if (state_q == S_DUTY) begin
        wheel_q <= 1'b1;
        if (wheel_q) result_pend_q <= 1'b1;
      end
      // move a finished result into the output reg once it is free
      if (result_pend_q && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q   <= 1'b1;
        result_pend_q <= 1'b0;
      end else if (m_axis_tvalid_o && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  logic [OutDataW-1:0] out_data_q;
  always_ff @(posedge clk_i) begin
    if (in_fire && update) begin
      lat_q[0] <= cnt_new[0];
      lat_q[1] <= cnt_new[1];
      tgt_q[0] <= override ? TargetFallback : in_target[0];
      tgt_q[1] <= override ? TargetFallback : in_target[1];
    end
    case (state_q)
      S_SPEED: prod_q <= mul_p;
      S_ERR: begin
        speed_q[wheel_q] <= speed_sat;
        err_q <= $signed({1'b0, tgt_q[wheel_q]}) - $signed({1'b0, speed_sat});
      end
      S_PTERM: prod_q <= mul_p;
      S_ITERM: begin
        pterm_q <= prod_q;
        prod_q  <= mul_p;
      end
      S_SUM:   sum_q <= add_s;
      S_DUTY:  duty_q[wheel_q] <= duty_val;
      default: ;
    endcase
    if (result_pend_q && (!out_valid_q || m_axis_tready_i)) begin
      out_data_q <= {speed_q[1], speed_q[0], duty_q[1], duty_q[0]};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ----- sim/tb_dual_encoder_speed_pi_loop_unit.sv -----
// ----------------------------------------------------------------------------
// tb_dual_encoder_speed_pi_loop_unit
// self-checking bench for the two-wheel speed measurement and pi duty loop:
// beats go in over the input stream while a bit-accurate copy of the counters,
// tick period and both integrators predicts every control update, and each
// result beat is compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dual_encoder_speed_pi_loop_unit;
  import desp_pkg::*;

  // predicted duties and measured speeds of one control update
  typedef struct {
    logic [DutyW-1:0]  left_duty;
    logic [DutyW-1:0]  right_duty;
    logic [SpeedW-1:0] left_speed;
    logic [SpeedW-1:0] right_speed;
  } duty_speed_t;

  // how the random targets and edges of a beat are picked
  typedef enum int {
    MIX_NORMAL,
    MIX_DRIVE_UP,
    MIX_DRIVE_DOWN
  } target_mix_e;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of registers and state, queue of pending updates
  // --------------------------------------------------------------------------
  class speed_loop_scoreboard;
    int unsigned prop_gain, int_gain, duty_hi, duty_lo, period, scale;
    int unsigned pulses[2];
    int unsigned ticks;
    longint      integ[2];
    duty_speed_t update_q[$];
    int unsigned fail_count;

    function new();
      prop_gain  = PropGainRst;
      int_gain   = IntGainRst;
      duty_hi    = DutyHighRst;
      duty_lo    = DutyLowRst;
      period     = PeriodRst;
      scale      = SpeedScaleRst;
      pulses     = '{0, 0};
      ticks      = 0;
      integ      = '{0, 0};
      fail_count = 0;
    endfunction

    function void set_reg(reg_idx_e idx, int unsigned v);
      case (idx)
        REG_PROP_GAIN:   prop_gain = v & 'hFFFF;
        REG_INT_GAIN:    int_gain  = v & 'hFFFF;
        REG_DUTY_HIGH:   duty_hi   = v & 'hFF;
        REG_DUTY_LOW:    duty_lo   = v & 'hFF;
        REG_PERIOD:      period    = v & 'hFF;
        REG_SPEED_SCALE: scale     = v & 'hFFFF;
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return update_q.size();
    endfunction

    // count times scale, saturating at the speed width
    function int unsigned measure(int unsigned count);
      int unsigned v;
      v = count * scale;
      return (v > 65535) ? 65535 : v;
    endfunction

    // one pi step for one wheel, integrator saturates at its own width
    function int unsigned pi_duty(int side, int unsigned tgt, int unsigned spd);
      longint imax, err, sum;
      imax = (longint'(1) <<< (IntegBitsDefault - 1)) - 1;
      err  = longint'(tgt) - longint'(spd);
      integ[side] += longint'(int_gain) * err;
      if (integ[side] > imax) begin
        integ[side] = imax;
      end else if (integ[side] < -imax - 1) begin
        integ[side] = -imax - 1;
      end
      sum = longint'(prop_gain) * err + integ[side];
      // high clamp is tested first, so crossed limits give duty_hi above it and duty_lo otherwise
      if (sum > (longint'(duty_hi) <<< FracW)) return duty_hi;
      if (sum < (longint'(duty_lo) <<< FracW)) return duty_lo;
      return int'(sum >>> FracW) & 'hFF;
    endfunction

    function void note_input(bit tick, int unsigned le, int unsigned re,
                             int unsigned lt, int unsigned rt);
      int unsigned per, ls, rs;
      duty_speed_t r;
      // edges of this beat go in before any latch
      pulses[0] = (pulses[0] + le > 65535) ? 65535 : pulses[0] + le;
      pulses[1] = (pulses[1] + re > 65535) ? 65535 : pulses[1] + re;
      if (!tick) return;
      per   = (period == 0) ? 1 : period;
      ticks = (ticks + 1) & 'h1FF;
      if (ticks < per) return;
      ticks = 0;
      ls = measure(pulses[0]);
      rs = measure(pulses[1]);
      pulses = '{0, 0};
      if (lt > TargetLimit || rt > TargetLimit) begin
        lt = TargetFallback;
        rt = TargetFallback;
      end
      r.left_duty   = pi_duty(0, lt, ls);
      r.right_duty  = pi_duty(1, rt, rs);
      r.left_speed  = ls;
      r.right_speed = rs;
      update_q.push_back(r);
    endfunction

    function void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        fail_count++;
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] d);
      duty_speed_t e;
      if (update_q.size() == 0) begin
        $display("%0t: result beat %h with no update pending, expected none", $time, d);
        fail_count++;
        return;
      end
      e = update_q.pop_front();
      check_field("left_duty",   e.left_duty,   d[7:0]);
      check_field("right_duty",  e.right_duty,  d[15:8]);
      check_field("left_speed",  e.left_speed,  d[31:16]);
      check_field("right_speed", e.right_speed, d[47:32]);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block signals
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = REG_PROP_GAIN;
  logic [CfgW-1:0]     cfg_data = '0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  // left_edges[1:0], right_edges[3:2], left_target[19:4], right_target[35:20]
  logic [InDataW-1:0]  s_data = '0;
  // tick[0]
  logic [0:0]          s_user = 1'b0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  // left_duty[7:0], right_duty[15:8], left_speed[31:16], right_speed[47:32]
  logic [OutDataW-1:0] m_data;

  // receiver side: one long hold-off on request, otherwise a rotating pattern
  logic        hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rx_cycle = 0;
  logic [15:0] ready_pattern = 16'hFFFF;

  speed_loop_scoreboard sb;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  dual_encoder_speed_pi_loop_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  // --------------------------------------------------------------------------
  // result side: check the accepted beat, then pick tready for the next edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    // values read here are the ones the block saw at this edge
    if (rst_n && m_valid && m_ready) sb.check_result(m_data);
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      // long stall so the output register fills and the input backs up
      hold_done = 1'b1;
      hold_left = 300;
      m_ready <= 1'b0;
    end else begin
      if (rx_cycle % 128 == 0) begin
        // full-rate stretch or a random pattern with bit zero of each nibble forced on
        ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                    : 16'($urandom() | 16'h1111);
      end
      ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
      m_ready <= ready_pattern[0];
    end
    rx_cycle++;
  end

  // --------------------------------------------------------------------------
  // driving tasks, all called at a rising edge
  // --------------------------------------------------------------------------

  // offer one input beat and wait for the handshake
  task automatic send_beat(bit tick, int unsigned le, int unsigned re,
                           int unsigned lt, int unsigned rt);
    s_data  <= {4'd0, rt[15:0], lt[15:0], re[1:0], le[1:0]};
    s_user  <= tick;
    s_valid <= 1'b1;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sb.note_input(tick, le, re, lt, rt);
  endtask

  // register write; the caller drops cfg_we after the last one
  task automatic cfg_write(reg_idx_e idx, int unsigned v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v[CfgW-1:0];
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  // stop offering, let every pending update come out, then a latency margin
  task automatic wait_idle();
    s_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // mostly in-range targets, some above the override limit, some at extremes
  function automatic int unsigned pick_target();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return $urandom_range(0, 25600);
    if (sel < 85) return $urandom_range(0, 65535);
    if (sel < 95) return $urandom_range(25598, 25602);
    return sel[0] ? 65535 : 0;
  endfunction

  function automatic int unsigned pick_gain();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic random_config(bit crossed, int unsigned per_max);
    int unsigned hi, lo;
    if (crossed) begin
      hi = $urandom_range(0, 127);
      lo = $urandom_range(hi + 1, 255);
    end else begin
      hi = $urandom_range(0, 255);
      lo = $urandom_range(0, hi);
    end
    cfg_write(REG_PROP_GAIN, pick_gain());
    cfg_write(REG_INT_GAIN, pick_gain());
    cfg_write(REG_SPEED_SCALE, $urandom_range(0, 1) ? $urandom_range(0, 3000) : pick_gain());
    cfg_write(REG_DUTY_HIGH, hi);
    cfg_write(REG_DUTY_LOW, lo);
    cfg_write(REG_PERIOD, $urandom_range(1, per_max));
    cfg_we <= 1'b0;
  endtask

  // random beats sent in bursts, with random gaps between them when gaps_on is set
  task automatic run_phase(int unsigned n, int unsigned tick_pct, target_mix_e mix,
                           bit gaps_on);
    int unsigned burst, gap, le, re, lt, rt;
    bit          tick;
    target_mix_e m;
    burst = $urandom_range(1, 24);
    for (int unsigned i = 0; i < n; i++) begin
      // a few plain beats mixed into the driving phases
      m    = ($urandom_range(0, 19) == 0) ? MIX_NORMAL : mix;
      tick = ($urandom_range(1, 100) <= tick_pct);
      case (m)
        MIX_DRIVE_UP: begin
          // targets just under the limit push the integrators up
          le = $urandom_range(0, 3);
          re = $urandom_range(0, 3);
          lt = $urandom_range(24000, 25600);
          rt = $urandom_range(24000, 25600);
        end
        MIX_DRIVE_DOWN: begin
          // edges every beat with low targets push them down
          le = $urandom_range(1, 3);
          re = $urandom_range(1, 3);
          lt = $urandom_range(0, 300);
          rt = $urandom_range(0, 300);
        end
        default: begin
          le = $urandom_range(0, 3);
          re = $urandom_range(0, 3);
          lt = pick_target();
          rt = pick_target();
        end
      endcase
      send_beat(tick, le, re, lt, rt);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
          s_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings (period 10): edge value three without a tick,
    // targets at both extremes and around the override limit
    send_beat(0, 3, 3, 0, 0);
    send_beat(1, 0, 3, 65535, 65535);
    send_beat(1, 3, 0, 0, 65535);
    send_beat(1, 2, 1, 25600, 0);
    send_beat(1, 1, 2, 25601, 25601);
    wait_idle();

    // period lowered below the tick count: the next tick updates,
    // and the edges of that beat are counted before the latch
    cfg_write(REG_PERIOD, 2);
    cfg_we <= 1'b0;
    send_beat(1, 3, 3, 25600, 25600);
    wait_idle();

    // period zero behaves as one
    cfg_write(REG_PERIOD, 0);
    cfg_we <= 1'b0;
    send_beat(1, 3, 1, 25601, 0);
    send_beat(1, 0, 2, 0, 25601);
    send_beat(0, 3, 3, 100, 100);
    send_beat(0, 3, 3, 100, 100);
    send_beat(1, 3, 3, 0, 0);
    send_beat(1, 1, 0, 65535, 25600);
    send_beat(1, 0, 0, 25600, 0);
    wait_idle();

    // largest gains and scale: speed saturates, large errors both ways
    cfg_write(REG_PROP_GAIN, 65535);
    cfg_write(REG_INT_GAIN, 65535);
    cfg_write(REG_DUTY_HIGH, 255);
    cfg_write(REG_DUTY_LOW, 0);
    cfg_write(REG_SPEED_SCALE, 65535);
    cfg_we <= 1'b0;
    send_beat(1, 3, 0, 0, 25600);
    send_beat(1, 3, 1, 0, 25600);
    send_beat(1, 0, 0, 25600, 25600);
    send_beat(1, 0, 0, 25600, 25600);
    wait_idle();

    // crossed clamp limits, duty_low above duty_high
    cfg_write(REG_DUTY_HIGH, 50);
    cfg_write(REG_DUTY_LOW, 200);
    cfg_write(REG_PROP_GAIN, 4000);
    cfg_write(REG_INT_GAIN, 300);
    cfg_we <= 1'b0;
    send_beat(1, 0, 0, 25600, 0);
    send_beat(1, 2, 3, 0, 25600);
    send_beat(1, 1, 1, 12000, 3000);
    send_beat(1, 0, 3, 25600, 25600);
    wait_idle();

    // back to the reset values, slow update rate
    cfg_write(REG_PROP_GAIN, PropGainRst);
    cfg_write(REG_INT_GAIN, IntGainRst);
    cfg_write(REG_DUTY_HIGH, DutyHighRst);
    cfg_write(REG_DUTY_LOW, DutyLowRst);
    cfg_write(REG_PERIOD, PeriodRst);
    cfg_write(REG_SPEED_SCALE, SpeedScaleRst);
    cfg_we <= 1'b0;
    run_phase(100, 90, MIX_NORMAL, 1'b1);
    wait_idle();

    // every register at its minimum but the period, which is one
    cfg_write(REG_PROP_GAIN, 0);
    cfg_write(REG_INT_GAIN, 0);
    cfg_write(REG_DUTY_HIGH, 0);
    cfg_write(REG_DUTY_LOW, 0);
    cfg_write(REG_PERIOD, 1);
    cfg_write(REG_SPEED_SCALE, 0);
    cfg_we <= 1'b0;
    run_phase(60, 60, MIX_NORMAL, 1'b1);
    wait_idle();

    // drive both integrators into positive saturation, update on every tick;
    // the receiver holds off for a long stretch at the start
    cfg_write(REG_PROP_GAIN, pick_gain());
    cfg_write(REG_INT_GAIN, 65535);
    cfg_write(REG_DUTY_HIGH, 255);
    cfg_write(REG_DUTY_LOW, 0);
    cfg_write(REG_PERIOD, 1);
    cfg_write(REG_SPEED_SCALE, 0);
    cfg_we   <= 1'b0;
    hold_req <= 1'b1;
    run_phase(380, 100, MIX_DRIVE_UP, 1'b1);
    wait_idle();

    // all the way down to negative saturation, back-to-back beats
    cfg_write(REG_PROP_GAIN, pick_gain());
    cfg_write(REG_DUTY_HIGH, $urandom_range(128, 255));
    cfg_write(REG_DUTY_LOW, $urandom_range(0, 127));
    cfg_write(REG_SPEED_SCALE, 65535);
    cfg_we <= 1'b0;
    run_phase(300, 100, MIX_DRIVE_DOWN, 1'b0);
    wait_idle();

    // random settings, fast updates
    random_config(1'b0, 8);
    run_phase(60, 80, MIX_NORMAL, 1'b1);
    wait_idle();

    random_config(1'b1, 8);
    run_phase(60, 80, MIX_NORMAL, 1'b1);
    wait_idle();

    // longest period: one update after 255 ticks
    random_config(1'b0, 8);
    cfg_write(REG_PERIOD, 255);
    cfg_we <= 1'b0;
    run_phase(256, 100, MIX_NORMAL, 1'b0);
    wait_idle();

    // long edge run between ticks: scale one shows the raw count
    cfg_write(REG_PROP_GAIN, pick_gain());
    cfg_write(REG_INT_GAIN, pick_gain());
    cfg_write(REG_DUTY_HIGH, 255);
    cfg_write(REG_DUTY_LOW, 0);
    cfg_write(REG_PERIOD, 1);
    cfg_write(REG_SPEED_SCALE, 1);
    cfg_we <= 1'b0;
    send_beat(1, 0, 0, 0, 0);
    repeat (40) send_beat(0, 3, 3, pick_target(), pick_target());
    send_beat(1, 3, 3, 25600, 25600);
    wait_idle();

    random_config(1'b0, 6);
    run_phase(60, 85, MIX_NORMAL, 1'b1);
    wait_idle();

    if (sb.fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard limit on the whole run
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
